### rtl/time_window_event_builder_assert.svh
// assertion macros used by the event builder checker
`ifndef TIME_WINDOW_EVENT_BUILDER_ASSERT_SVH
`define TIME_WINDOW_EVENT_BUILDER_ASSERT_SVH

// property checked on every clock edge outside reset
`define TWB_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define TWB_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/twb_pkg.sv
// shared types, constants and codes of the time window event builder
package twb_pkg;

    // field widths
    localparam int TIME_BITS     = 48;
    localparam int ENERGY_BITS   = 16;
    localparam int STRIP_BITS    = 6;
    localparam int RANK_BITS     = 3;
    localparam int COUNT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 48;

    // default list depth per side
    localparam int MAX_HITS_DEF = 8;

    // register reset values
    localparam logic [TIME_BITS-1:0]   WINDOW_RST    = 48'd1000;
    localparam logic [ENERGY_BITS-1:0] FRONT_THR_RST = 16'd80;
    localparam logic [ENERGY_BITS-1:0] BACK_THR_RST  = 16'd200;

    // input and output codes
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic SIDE_FRONT = 1'b0;
    localparam logic SIDE_BACK  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW    = 2'd0,
        CFG_FRONT_THR = 2'd1,
        CFG_BACK_THR  = 2'd2
    } t_cfg_idx;

    // one stored hit
    typedef struct packed {
        logic [STRIP_BITS-1:0]  strip;
        logic [ENERGY_BITS-1:0] energy;
        logic [TIME_BITS-1:0]   time_stamp;
    } t_hit;

    // operation applied to a row of cells
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    // control broadcast along a row of cells
    typedef struct packed {
        t_cell_op op;
        t_hit     hit;
    } t_cell_ctrl;

    // one emitted result
    typedef struct packed {
        logic                   side;
        logic [RANK_BITS-1:0]   rank;
        logic [STRIP_BITS-1:0]  strip;
        logic [ENERGY_BITS-1:0] energy;
        logic [TIME_BITS-1:0]   time_stamp;
        logic [COUNT_BITS-1:0]  front_count;
        logic [COUNT_BITS-1:0]  back_count;
        logic                   last;
    } t_result;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN_F,
        ST_DRAIN_B,
        ST_FINISH
    } t_state;

endpackage

### rtl/twb_in_if.sv
// input channel: hits and flush requests
interface twb_in_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic                             hit_side;
    logic [twb_pkg::STRIP_BITS-1:0]   hit_strip;
    logic [twb_pkg::ENERGY_BITS-1:0]  hit_energy;
    logic [twb_pkg::TIME_BITS-1:0]    hit_time;

    modport source (
        output valid, kind, hit_side, hit_strip, hit_energy, hit_time,
        input  ready
    );
    modport sink (
        input  valid, kind, hit_side, hit_strip, hit_energy, hit_time,
        output ready
    );
endinterface

### rtl/twb_out_if.sv
// output channel: hits of built events
interface twb_out_if;
    logic                             valid;
    logic                             ready;
    logic                             out_side;
    logic [twb_pkg::RANK_BITS-1:0]    out_rank;
    logic [twb_pkg::STRIP_BITS-1:0]   out_strip;
    logic [twb_pkg::ENERGY_BITS-1:0]  out_energy;
    logic [twb_pkg::TIME_BITS-1:0]    out_time;
    logic [twb_pkg::COUNT_BITS-1:0]   front_count;
    logic [twb_pkg::COUNT_BITS-1:0]   back_count;
    logic                             last_of_event;

    modport source (
        output valid, out_side, out_rank, out_strip, out_energy, out_time,
               front_count, back_count, last_of_event,
        input  ready
    );
    modport sink (
        input  valid, out_side, out_rank, out_strip, out_energy, out_time,
               front_count, back_count, last_of_event,
        output ready
    );
endinterface

### rtl/time_window_event_builder.sv
// event builder top level: hits in, sorted per-side event hits out
// a hit that joins or opens an event passes through ST_EXEC and back to idle before the next acceptance
// a closing hit or flush drains the stored hits through ST_DRAIN_F, ST_DRAIN_B and ST_FINISH,
// one output per cycle while the output register is not stalled; the single drain sequencer sets the rate
// synchronous active-low reset clears counts, reference time, output valid and
// restores register defaults; list contents are not cleared
module time_window_event_builder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [twb_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [twb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    twb_in_if.sink                             i_in,
    twb_out_if.source                          o_out
);

    // list depth is the package default, which the rank and count widths of the output channel can hold
    localparam int MAX_HITS = twb_pkg::MAX_HITS_DEF;
    localparam int CNT_W    = $clog2(MAX_HITS + 1);

    // configuration registers
    logic [twb_pkg::TIME_BITS-1:0]   r_window;
    logic [twb_pkg::ENERGY_BITS-1:0] r_front_thr;
    logic [twb_pkg::ENERGY_BITS-1:0] r_back_thr;

    // accepted item
    logic                            r_kind;
    logic                            r_side;
    logic                            r_keep;
    logic                            r_close;
    twb_pkg::t_hit                   r_hit;

    // sequencer and event state
    twb_pkg::t_state                 r_state, n_state;
    logic [twb_pkg::TIME_BITS-1:0]   r_ref, n_ref;
    logic [CNT_W-1:0]                r_ef, n_ef;
    logic [CNT_W-1:0]                r_eb, n_eb;
    logic [CNT_W-1:0]                r_rank, n_rank;
    logic                            r_pend, n_pend;

    // output register
    twb_pkg::t_result                r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    twb_pkg::t_cell_ctrl             w_front_ctrl;
    twb_pkg::t_cell_ctrl             w_back_ctrl;
    twb_pkg::t_hit                   w_front_head;
    twb_pkg::t_hit                   w_back_head;
    logic [CNT_W-1:0]                w_front_cnt;
    logic [CNT_W-1:0]                w_back_cnt;
    logic                            w_accept;
    logic                            w_slot_free;
    logic                            w_empty;
    logic [twb_pkg::TIME_BITS-1:0]   w_dist;
    logic                            w_keep;

    assign i_in.ready  = (r_state == twb_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_empty     = (w_front_cnt == '0) && (w_back_cnt == '0);

    // distance to the reference and threshold test, taken at acceptance
    assign w_dist = (i_in.hit_time >= r_ref) ? (i_in.hit_time - r_ref)
                                             : (r_ref - i_in.hit_time);
    assign w_keep = (i_in.hit_side == twb_pkg::SIDE_FRONT) ? (i_in.hit_energy >= r_front_thr)
                                                           : (i_in.hit_energy >= r_back_thr);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= twb_pkg::WINDOW_RST;
            r_front_thr <= twb_pkg::FRONT_THR_RST;
            r_back_thr  <= twb_pkg::BACK_THR_RST;
        end else if (i_cfg_we) begin
            unique case (twb_pkg::t_cfg_idx'(i_cfg_idx))
                twb_pkg::CFG_WINDOW:    r_window    <= twb_pkg::TIME_BITS'(i_cfg_data);
                twb_pkg::CFG_FRONT_THR: r_front_thr <= twb_pkg::ENERGY_BITS'(i_cfg_data);
                twb_pkg::CFG_BACK_THR:  r_back_thr  <= twb_pkg::ENERGY_BITS'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind           <= i_in.kind;
            r_side           <= i_in.hit_side;
            r_keep           <= w_keep;
            r_close          <= (w_dist >= r_window);
            r_hit.strip      <= i_in.hit_strip;
            r_hit.energy     <= i_in.hit_energy;
            r_hit.time_stamp <= i_in.hit_time;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twb_pkg::ST_IDLE;
            r_ref       <= '0;
            r_ef        <= '0;
            r_eb        <= '0;
            r_rank      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref       <= n_ref;
            r_ef        <= n_ef;
            r_eb        <= n_eb;
            r_rank      <= n_rank;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // next state, list operations and emission
    always_comb begin
        n_state          = r_state;
        n_ref            = r_ref;
        n_ef             = r_ef;
        n_eb             = r_eb;
        n_rank           = r_rank;
        n_pend           = r_pend;
        n_out            = r_out;
        n_out_valid      = r_out_valid && !o_out.ready;
        w_front_ctrl.op  = twb_pkg::CELL_HOLD;
        w_front_ctrl.hit = r_hit;
        w_back_ctrl.op   = twb_pkg::CELL_HOLD;
        w_back_ctrl.hit  = r_hit;

        unique case (r_state)
            twb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = twb_pkg::ST_EXEC;
                end
            end

            twb_pkg::ST_EXEC: begin
                if ((r_kind == twb_pkg::KIND_FLUSH) && w_empty) begin
                    n_state = twb_pkg::ST_IDLE;
                end else if ((r_kind == twb_pkg::KIND_HIT) && (w_empty || !r_close)) begin
                    // hit opens or joins the event
                    if (r_keep && (r_side == twb_pkg::SIDE_FRONT)) begin
                        w_front_ctrl.op = twb_pkg::CELL_INSERT;
                    end
                    if (r_keep && (r_side == twb_pkg::SIDE_BACK)) begin
                        w_back_ctrl.op = twb_pkg::CELL_INSERT;
                    end
                    if (w_empty) begin
                        n_ref = r_hit.time_stamp;
                    end
                    n_state = twb_pkg::ST_IDLE;
                end else begin
                    // close the event: snapshot counts, then drain
                    n_pend          = (r_kind == twb_pkg::KIND_HIT);
                    n_ef            = w_front_cnt;
                    n_eb            = w_back_cnt;
                    n_rank          = '0;
                    w_front_ctrl.op = twb_pkg::CELL_CLEAR;
                    w_back_ctrl.op  = twb_pkg::CELL_CLEAR;
                    n_state = (w_front_cnt != '0) ? twb_pkg::ST_DRAIN_F : twb_pkg::ST_DRAIN_B;
                end
            end

            twb_pkg::ST_DRAIN_F: begin
                if (w_slot_free) begin
                    n_out.side        = twb_pkg::SIDE_FRONT;
                    n_out.rank        = twb_pkg::RANK_BITS'(r_rank);
                    n_out.strip       = w_front_head.strip;
                    n_out.energy      = w_front_head.energy;
                    n_out.time_stamp  = w_front_head.time_stamp;
                    n_out.front_count = twb_pkg::COUNT_BITS'(r_ef);
                    n_out.back_count  = twb_pkg::COUNT_BITS'(r_eb);
                    n_out.last        = (r_rank == (r_ef - CNT_W'(1))) && (r_eb == '0);
                    n_out_valid       = 1'b1;
                    w_front_ctrl.op   = twb_pkg::CELL_SHIFT;
                    if (r_rank == (r_ef - CNT_W'(1))) begin
                        n_rank  = '0;
                        n_state = (r_eb != '0) ? twb_pkg::ST_DRAIN_B : twb_pkg::ST_FINISH;
                    end else begin
                        n_rank = r_rank + CNT_W'(1);
                    end
                end
            end

            twb_pkg::ST_DRAIN_B: begin
                if (w_slot_free) begin
                    n_out.side        = twb_pkg::SIDE_BACK;
                    n_out.rank        = twb_pkg::RANK_BITS'(r_rank);
                    n_out.strip       = w_back_head.strip;
                    n_out.energy      = w_back_head.energy;
                    n_out.time_stamp  = w_back_head.time_stamp;
                    n_out.front_count = twb_pkg::COUNT_BITS'(r_ef);
                    n_out.back_count  = twb_pkg::COUNT_BITS'(r_eb);
                    n_out.last        = (r_rank == (r_eb - CNT_W'(1)));
                    n_out_valid       = 1'b1;
                    w_back_ctrl.op    = twb_pkg::CELL_SHIFT;
                    if (r_rank == (r_eb - CNT_W'(1))) begin
                        n_rank  = '0;
                        n_state = twb_pkg::ST_FINISH;
                    end else begin
                        n_rank = r_rank + CNT_W'(1);
                    end
                end
            end

            twb_pkg::ST_FINISH: begin
                // the closing hit starts the fresh event
                if (r_pend) begin
                    if (r_keep && (r_side == twb_pkg::SIDE_FRONT)) begin
                        w_front_ctrl.op = twb_pkg::CELL_INSERT;
                    end
                    if (r_keep && (r_side == twb_pkg::SIDE_BACK)) begin
                        w_back_ctrl.op = twb_pkg::CELL_INSERT;
                    end
                    n_ref = r_hit.time_stamp;
                end
                n_state = twb_pkg::ST_IDLE;
            end

            default: begin
                n_state = twb_pkg::ST_IDLE;
            end
        endcase
    end

    // per-side hit lists
    twb_chain #(
        .MAX_HITS (MAX_HITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_front_ctrl),
        .o_head  (w_front_head),
        .o_count (w_front_cnt)
    );

    twb_chain #(
        .MAX_HITS (MAX_HITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_back_ctrl),
        .o_head  (w_back_head),
        .o_count (w_back_cnt)
    );

    // output channel
    assign o_out.valid         = r_out_valid;
    assign o_out.out_side      = r_out.side;
    assign o_out.out_rank      = r_out.rank;
    assign o_out.out_strip     = r_out.strip;
    assign o_out.out_energy    = r_out.energy;
    assign o_out.out_time      = r_out.time_stamp;
    assign o_out.front_count   = r_out.front_count;
    assign o_out.back_count    = r_out.back_count;
    assign o_out.last_of_event = r_out.last;

endmodule

### rtl/twb_cell.sv
// one entry of the sorted hit list: keeps, takes the new hit, or takes a neighbor
module twb_cell (
    input  logic                i_clk,
    input  twb_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  logic                i_left_ge,
    input  twb_pkg::t_hit       i_left,
    input  twb_pkg::t_hit       i_right,
    output twb_pkg::t_hit       o_entry,
    output logic                o_ge
);

    twb_pkg::t_hit r_entry;
    twb_pkg::t_hit n_entry;
    logic          w_ge;

    // stored hit ranks ahead of the new one (ties keep arrival order)
    assign w_ge = i_valid && (r_entry.energy >= i_ctrl.hit.energy);

    // insert: first cell not ahead takes the new hit, later ones take the left neighbor
    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            twb_pkg::CELL_INSERT: begin
                if (!w_ge) begin
                    n_entry = i_left_ge ? i_ctrl.hit : i_left;
                end
            end
            twb_pkg::CELL_SHIFT: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_ge    = w_ge;

endmodule

### rtl/twb_chain.sv
// row of cells holding one side's hit list, sorted by descending energy
module twb_chain #(
    parameter  int MAX_HITS = twb_pkg::MAX_HITS_DEF,
    localparam int CNT_W    = $clog2(MAX_HITS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twb_pkg::t_cell_ctrl i_ctrl,
    output twb_pkg::t_hit       o_head,
    output logic [CNT_W-1:0]    o_count
);

    twb_pkg::t_hit        w_entry [MAX_HITS];
    twb_pkg::t_hit        w_left  [MAX_HITS];
    twb_pkg::t_hit        w_right [MAX_HITS];
    logic [MAX_HITS-1:0]  w_ge;
    logic [MAX_HITS-1:0]  w_left_ge;
    logic [MAX_HITS-1:0]  w_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    // neighbor wiring of the row
    for (genvar i = 0; i < MAX_HITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i]    = '0;
            assign w_left_ge[i] = 1'b1;
        end else begin : g_inner
            assign w_left[i]    = w_entry[i-1];
            assign w_left_ge[i] = w_ge[i-1];
        end
        if (i == MAX_HITS - 1) begin : g_last
            assign w_right[i] = w_entry[i];
        end else begin : g_body
            assign w_right[i] = w_entry[i+1];
        end
        assign w_valid[i] = r_count > CNT_W'(i);

        twb_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (i_ctrl),
            .i_valid   (w_valid[i]),
            .i_left_ge (w_left_ge[i]),
            .i_left    (w_left[i]),
            .i_right   (w_right[i]),
            .o_entry   (w_entry[i]),
            .o_ge      (w_ge[i])
        );
    end

    // fill count: an insert into a full list either replaces the tail or is dropped
    always_comb begin
        n_count = r_count;
        case (i_ctrl.op)
            twb_pkg::CELL_CLEAR: begin
                n_count = '0;
            end
            twb_pkg::CELL_INSERT: begin
                if (r_count < CNT_W'(MAX_HITS)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_entry[0];
    assign o_count = r_count;

endmodule

### rtl/twb_checker.sv
// port-level checks of the event builder output, bound to the top level
`include "time_window_event_builder_assert.svh"

module twb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_side,
    input logic [twb_pkg::RANK_BITS-1:0]    i_out_rank,
    input logic [twb_pkg::COUNT_BITS-1:0]   i_front_count,
    input logic [twb_pkg::COUNT_BITS-1:0]   i_back_count,
    input logic                             i_out_last
);

    // output empties after reset
    `TWB_ASSERT_ALL(a_reset_clears, (!i_rst_n |=> !i_out_valid), "output valid after reset")

    // rank stays inside its side's count
    `TWB_ASSERT_RUN(a_rank_range, (i_out_valid |-> (4'(i_out_rank) < (i_out_side ? i_back_count : i_front_count))), "rank beyond side count")

    // last transaction carries the last rank of its side
    `TWB_ASSERT_RUN(a_last_rank, ((i_out_valid && i_out_last) |-> ((4'(i_out_rank) + 4'd1) == (i_out_side ? i_back_count : i_front_count))), "last flag on wrong rank")

    // an event ends on a front hit only when it has no back hits
    `TWB_ASSERT_RUN(a_last_front, ((i_out_valid && i_out_last && !i_out_side) |-> (i_back_count == 4'd0)), "front hit closes event with back hits")

endmodule

bind time_window_event_builder twb_checker u_twb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_side    (o_out.out_side),
    .i_out_rank    (o_out.out_rank),
    .i_front_count (o_out.front_count),
    .i_back_count  (o_out.back_count),
    .i_out_last    (o_out.last_of_event)
);
